// ===== rtl/bsta_pkg.sv =====
package bsta_pkg;

	localparam int MAX_TOKENS = 1024;
	localparam int TYPE_CODES = 16;
	localparam int POS_W      = 10;
	localparam int LEN_W      = 11;
	localparam int TYPE_W     = 4;
	localparam int KIND_W     = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int MAX_RESULTS = 3;
	localparam int CNT_W      = 2;

	localparam logic [POS_W-1:0]  LAST_POS = POS_W'(MAX_TOKENS - 1);
	localparam logic [LEN_W-1:0]  MAX_LEN  = LEN_W'(MAX_TOKENS);

	localparam logic [KIND_W-1:0] TAG_OUTSIDE = 2'd0;
	localparam logic [KIND_W-1:0] TAG_BEGIN   = 2'd1;
	localparam logic [KIND_W-1:0] TAG_INSIDE  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_SUBJECT_TYPE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OBJECT_TYPE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_VALUE_TYPE   = 2'd2;

	localparam logic [TYPE_W-1:0] SUBJECT_TYPE_RST = 4'd1;
	localparam logic [TYPE_W-1:0] OBJECT_TYPE_RST  = 4'd2;
	localparam logic [TYPE_W-1:0] VALUE_TYPE_RST   = 4'd3;

	typedef struct packed {
		logic [POS_W-1:0] start;
		logic [LEN_W-1:0] length;
	} span_t;

	typedef struct packed {
		span_t subject;
		logic  has_object;
		span_t object;
		logic  has_value;
		span_t value;
	} triple_t;

	typedef struct packed {
		triple_t [MAX_RESULTS-1:0] triple;
		logic [CNT_W-1:0]          count;
	} bundle_t;

	typedef struct packed {
		logic [TYPE_W-1:0] subject_type;
		logic [TYPE_W-1:0] object_type;
		logic [TYPE_W-1:0] value_type;
	} roles_t;

	typedef struct packed {
		logic  subject_valid;
		span_t subject;
		logic  pending_valid;
		span_t pending;
	} ctx_t;

	typedef struct packed {
		bundle_t head;
		logic    empty;
	} queue_head_t;

endpackage

// ===== rtl/bio_span_triple_assembler.sv =====
// Groups BIO-tagged tokens into entity spans and emits subject, object and value triples as
// start positions and lengths. The front takes one token per cycle whenever the queue of
// QUEUE_DEPTH token bundles has room, and a token that causes no triple never enters the queue.
// The back hands out one triple per cycle through its output register while not stalled, so a
// token that causes two or three triples hands them out in turn from one queue entry;
// the first triple of a token passes the queue and then the output register before it is offered
// on the outputs. Role registers should be written only while no transaction is in flight.
module bio_span_triple_assembler import bsta_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write_enable,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [TYPE_W-1:0]    cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [KIND_W-1:0]    tag_kind,
	input  logic [TYPE_W-1:0]    tag_type,
	input  logic                 end_of_sequence,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [POS_W-1:0]     subject_start,
	output logic [LEN_W-1:0]     subject_length,
	output logic                 has_object,
	output logic [POS_W-1:0]     object_start,
	output logic [LEN_W-1:0]     object_length,
	output logic                 has_value,
	output logic [POS_W-1:0]     value_start,
	output logic [LEN_W-1:0]     value_length,
	output logic                 last_of_run
);

	logic        accept;
	logic        push;
	bundle_t     push_bundle;
	logic        full;
	logic        pop;
	queue_head_t head;
	triple_t     out_triple;

	assign in_stall = full;
	assign accept   = in_valid && !full;

	bsta_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_write_enable(cfg_write_enable),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.accept          (accept),
		.tag_kind        (tag_kind),
		.tag_type        (tag_type),
		.end_of_sequence (end_of_sequence),
		.push            (push),
		.push_bundle     (push_bundle)
	);

	bsta_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_bundle(push_bundle),
		.pop        (pop),
		.full       (full),
		.head       (head)
	);

	bsta_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_triple(out_triple),
		.out_last  (last_of_run)
	);

	assign subject_start  = out_triple.subject.start;
	assign subject_length = out_triple.subject.length;
	assign has_object     = out_triple.has_object;
	assign object_start   = out_triple.object.start;
	assign object_length  = out_triple.object.length;
	assign has_value      = out_triple.has_value;
	assign value_start    = out_triple.value.start;
	assign value_length   = out_triple.value.length;

endmodule

// ===== rtl/bsta_front.sv =====
module bsta_front import bsta_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write_enable,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [TYPE_W-1:0]    cfg_data,
	input  logic                 accept,
	input  logic [KIND_W-1:0]    tag_kind,
	input  logic [TYPE_W-1:0]    tag_type,
	input  logic                 end_of_sequence,
	output logic                 push,
	output bundle_t              push_bundle
);

	typedef struct packed {
		ctx_t    ctx;
		logic    emit;
		triple_t trip;
	} take_t;

	roles_t            roles_q;
	ctx_t              ctx_q;
	logic [TYPE_W-1:0] open_type_q;
	span_t             open_q;
	logic [POS_W-1:0]  pos_q;

	ctx_t              ctx_d;
	logic [TYPE_W-1:0] open_type_d;
	span_t             open_d;
	logic [POS_W-1:0]  pos_d;
	bundle_t           bundle_d;
	logic [TYPE_W-1:0] typ;
	logic              close1;
	take_t             tk1;
	take_t             tk2;

	function automatic triple_t make_triple(span_t subj, logic has_obj, span_t obj,
			logic has_val, span_t val);
		triple_t r;
		r.subject    = subj;
		r.has_object = has_obj;
		r.object     = has_obj ? obj : '0;
		r.has_value  = has_val;
		r.value      = has_val ? val : '0;
		return r;
	endfunction

	// One closed span is taken as an entity; it causes at most one triple.
	function automatic take_t take_entity(ctx_t ctx, logic [TYPE_W-1:0] t, span_t sp,
			roles_t rl);
		take_t r;
		r.ctx  = ctx;
		r.emit = 1'b0;
		r.trip = '0;
		if (t == rl.subject_type) begin
			if (ctx.pending_valid) begin
				r.emit = 1'b1;
				r.trip = make_triple(ctx.subject, 1'b1, ctx.pending, 1'b0, '0);
			end
			r.ctx.pending_valid = 1'b0;
			r.ctx.pending       = '0;
			r.ctx.subject_valid = 1'b1;
			r.ctx.subject       = sp;
		end else if (ctx.subject_valid) begin
			if (ctx.pending_valid) begin
				r.emit = 1'b1;
				r.ctx.pending_valid = 1'b0;
				r.ctx.pending       = '0;
				if (t == rl.value_type) begin
					r.trip = make_triple(ctx.subject, 1'b1, ctx.pending, 1'b1, sp);
				end else begin
					r.trip = make_triple(ctx.subject, 1'b1, ctx.pending, 1'b0, '0);
					if (t == rl.object_type) begin
						r.ctx.pending_valid = 1'b1;
						r.ctx.pending       = sp;
					end
				end
			end else if (t == rl.object_type) begin
				r.ctx.pending_valid = 1'b1;
				r.ctx.pending       = sp;
			end else if (t == rl.value_type) begin
				r.emit = 1'b1;
				r.trip = make_triple(ctx.subject, 1'b0, '0, 1'b1, sp);
			end
		end
		return r;
	endfunction

	always_comb begin
		ctx_d       = ctx_q;
		open_type_d = open_type_q;
		open_d      = open_q;
		pos_d       = pos_q;
		bundle_d    = '0;
		close1      = 1'b0;
		tk2         = '0;
		if (int'(tag_type) >= TYPE_CODES) begin
			typ = '0;
		end else begin
			typ = tag_type;
		end
		case (tag_kind)
			TAG_BEGIN: begin
				close1 = 1'b1;
			end
			TAG_INSIDE: begin
				if (open_type_q != '0 && open_type_q == typ) begin
					if (open_q.length < MAX_LEN) begin
						open_d.length = open_q.length + LEN_W'(1);
					end
				end else if (!(open_type_q == '0 && typ == '0)) begin
					close1 = 1'b1;
				end
			end
			default: begin
				close1 = 1'b1;
			end
		endcase
		tk1 = take_entity(ctx_q, open_type_q, open_q, roles_q);
		if (close1) begin
			if (open_type_q != '0) begin
				ctx_d = tk1.ctx;
				if (tk1.emit) begin
					bundle_d.triple[bundle_d.count] = tk1.trip;
					bundle_d.count = bundle_d.count + CNT_W'(1);
				end
			end
			open_type_d = '0;
			open_d      = '0;
		end
		if (tag_kind == TAG_BEGIN && typ != '0) begin
			open_type_d   = typ;
			open_d.start  = pos_q;
			open_d.length = LEN_W'(1);
		end
		if (end_of_sequence) begin
			if (open_type_d != '0) begin
				tk2   = take_entity(ctx_d, open_type_d, open_d, roles_q);
				ctx_d = tk2.ctx;
				if (tk2.emit) begin
					bundle_d.triple[bundle_d.count] = tk2.trip;
					bundle_d.count = bundle_d.count + CNT_W'(1);
				end
			end
			if (ctx_d.pending_valid) begin
				bundle_d.triple[bundle_d.count] =
					make_triple(ctx_d.subject, 1'b1, ctx_d.pending, 1'b0, '0);
				bundle_d.count = bundle_d.count + CNT_W'(1);
			end
			ctx_d       = '0;
			open_type_d = '0;
			open_d      = '0;
			pos_d       = '0;
		end else if (pos_q < LAST_POS) begin
			pos_d = pos_q + POS_W'(1);
		end
	end

	assign push        = accept && (bundle_d.count != '0);
	assign push_bundle = bundle_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			roles_q     <= '{subject_type: SUBJECT_TYPE_RST, object_type: OBJECT_TYPE_RST,
				value_type: VALUE_TYPE_RST};
			ctx_q       <= '0;
			open_type_q <= '0;
			open_q      <= '0;
			pos_q       <= '0;
		end else begin
			if (cfg_write_enable) begin
				case (cfg_index)
					CFG_SUBJECT_TYPE: roles_q.subject_type <= cfg_data;
					CFG_OBJECT_TYPE:  roles_q.object_type  <= cfg_data;
					CFG_VALUE_TYPE:   roles_q.value_type   <= cfg_data;
					default: begin
					end
				endcase
			end
			if (accept) begin
				ctx_q       <= ctx_d;
				open_type_q <= open_type_d;
				open_q      <= open_d;
				pos_q       <= pos_d;
			end
		end
	end

endmodule

// ===== rtl/bsta_queue.sv =====
module bsta_queue import bsta_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  bundle_t     push_bundle,
	input  logic        pop,
	output logic        full,
	output queue_head_t head
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_QW = $clog2(DEPTH + 1);

	bundle_t            mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_QW-1:0]  count_q;
	logic               do_pop;

	assign full       = (count_q == CNT_QW'(DEPTH));
	assign head.empty = (count_q == '0);
	assign head.head  = mem_q[rd_ptr_q];
	assign do_pop     = pop && !head.empty;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_bundle;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !do_pop) begin
				count_q <= count_q + CNT_QW'(1);
			end else if (do_pop && !push) begin
				count_q <= count_q - CNT_QW'(1);
			end
		end
	end

endmodule

// ===== rtl/bsta_back.sv =====
module bsta_back import bsta_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  queue_head_t head,
	output logic        pop,
	input  logic        out_stall,
	output logic        out_valid,
	output triple_t     out_triple,
	output logic        out_last
);

	logic             out_valid_q;
	triple_t          out_triple_q;
	logic             out_last_q;
	logic [CNT_W-1:0] idx_q;
	logic             load;
	logic             is_last;

	assign load    = !out_valid_q || !out_stall;
	assign is_last = (idx_q == head.head.count - CNT_W'(1));
	assign pop     = load && !head.empty && is_last;

	always_ff @(posedge clk) begin
		if (load && !head.empty) begin
			out_triple_q <= head.head.triple[idx_q];
			out_last_q   <= is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else if (load) begin
			out_valid_q <= !head.empty;
			if (!head.empty) begin
				idx_q <= is_last ? '0 : idx_q + CNT_W'(1);
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign out_triple = out_triple_q;
	assign out_last   = out_last_q;

endmodule
